FILE: hw/rtl/cdcf_pkg.sv
// shared types and constants for the character display cursor framer
`default_nettype none

package cdcf_pkg;

  // display geometry limits
  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 4;

  // field widths
  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int LINES_W    = 3;
  localparam int COLUMNS_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // opcodes
  localparam logic [1:0] OP_WRITE_AT  = 2'd0;
  localparam logic [1:0] OP_WRITE_CUR = 2'd1;
  localparam logic [1:0] OP_SET_CUR   = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

  // reset values of the configuration registers
  localparam logic [LINES_W-1:0]   LINE_COUNT_RST   = 3'd4;
  localparam logic [COLUMNS_W-1:0] COLUMN_COUNT_RST = 6'd20;

  // link bytes
  localparam logic [7:0] START_CMD  = 8'h1F;
  localparam logic [7:0] START_DATA = 8'h5F;
  localparam logic [7:0] CLEAR_CMD  = 8'h01;
  localparam logic [7:0] ROW_BASE_0 = 8'h80;
  localparam logic [7:0] ROW_BASE_1 = 8'hA0;
  localparam logic [7:0] ROW_BASE_2 = 8'hC0;
  localparam logic [7:0] ROW_BASE_3 = 8'hE0;

  // frame byte positions
  localparam logic [2:0] STEP_CLEAR_LAST = 3'd2;
  localparam logic [2:0] STEP_WRITE_LAST = 3'd5;

  // input request
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] target_col;
    logic [7:0] target_row;
    logic [7:0] char_code;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_last;
  } out_item_t;

  // frame job handed from front to back
  typedef struct packed {
    logic       is_clear;
    logic [7:0] addr;
    logic [7:0] char_code;
  } job_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cdcf_front.sv
// front end: configuration, cursor tracking and frame job generation
`default_nettype none

module cdcf_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire cdcf_pkg::in_item_t               in_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cdcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cdcf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             job_full,
  output logic                                  job_push,
  output cdcf_pkg::job_t                        job_data
);
  import cdcf_pkg::*;

  logic [LINES_W-1:0]   line_count_r;
  logic [COLUMNS_W-1:0] column_count_r;
  logic [COL_W-1:0]     cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0]     cursor_row_r, cursor_row_nxt;

  logic [COLUMNS_W-1:0] eff_cols;
  logic [LINES_W-1:0]   eff_rows;
  logic                 in_bounds;
  logic                 accept;
  logic                 do_write;
  logic [COL_W-1:0]     wr_col;
  logic [ROW_W-1:0]     wr_row;
  logic [7:0]           row_base;
  logic [COLUMNS_W-1:0] adv_col;
  logic [LINES_W-1:0]   adv_row;
  logic [COL_W-1:0]     next_col;
  logic [ROW_W-1:0]     next_row;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r   <= LINE_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_LINE_COUNT) begin
        line_count_r <= cfg_data[LINES_W-1:0];
      end
      if (cfg_index == CFG_COLUMN_COUNT) begin
        column_count_r <= cfg_data[COLUMNS_W-1:0];
      end
    end
  end

  // bounds clamped to the display limits
  assign eff_cols  = (column_count_r > COLUMNS_W'(MAX_COLUMNS)) ?
                     COLUMNS_W'(MAX_COLUMNS) : column_count_r;
  assign eff_rows  = (line_count_r > LINES_W'(MAX_ROWS)) ?
                     LINES_W'(MAX_ROWS) : line_count_r;
  assign in_bounds = ({2'b00, in_data.target_col} < {4'd0, eff_cols}) &&
                     ({2'b00, in_data.target_row} < {7'd0, eff_rows});

  // input side handshake
  assign in_full = job_full;
  assign accept  = in_push && !job_full;

  // write position: target for write-at, cursor otherwise
  always_comb begin
    do_write = 1'b0;
    wr_col   = cursor_col_r;
    wr_row   = cursor_row_r;
    unique case (in_data.opcode)
      OP_WRITE_AT: begin
        do_write = in_bounds;
        wr_col   = in_data.target_col[COL_W-1:0];
        wr_row   = in_data.target_row[ROW_W-1:0];
      end
      OP_WRITE_CUR: begin
        do_write = 1'b1;
      end
      OP_SET_CUR, OP_CLEAR: begin
        do_write = 1'b0;
      end
      default: begin
        do_write = 1'b0;
      end
    endcase
  end

  // row base lookup, two-line displays put row 1 at the third base
  always_comb begin
    unique case (wr_row)
      2'd0:    row_base = ROW_BASE_0;
      2'd1:    row_base = (line_count_r == 3'd2) ? ROW_BASE_2 : ROW_BASE_1;
      2'd2:    row_base = ROW_BASE_2;
      default: row_base = ROW_BASE_3;
    endcase
  end

  // cursor advance after a write, wrapping column then row
  always_comb begin
    adv_col = {1'b0, wr_col} + COLUMNS_W'(1);
    adv_row = {1'b0, wr_row};
    if (adv_col >= eff_cols || adv_col > COLUMNS_W'(MAX_COLUMNS - 1)) begin
      adv_col = '0;
      adv_row = adv_row + LINES_W'(1);
    end
    if (adv_row >= eff_rows || adv_row > LINES_W'(MAX_ROWS - 1)) begin
      adv_row = '0;
    end
    next_col = adv_col[COL_W-1:0];
    next_row = adv_row[ROW_W-1:0];
  end

  // next cursor
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    if (accept) begin
      unique case (in_data.opcode)
        OP_WRITE_AT, OP_WRITE_CUR: begin
          if (do_write) begin
            cursor_col_nxt = next_col;
            cursor_row_nxt = next_row;
          end
        end
        OP_SET_CUR: begin
          if (in_bounds) begin
            cursor_col_nxt = in_data.target_col[COL_W-1:0];
            cursor_row_nxt = in_data.target_row[ROW_W-1:0];
          end else begin
            cursor_col_nxt = '0;
            cursor_row_nxt = '0;
          end
        end
        default: begin
          cursor_col_nxt = '0;
          cursor_row_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

  // job to the back end
  assign job_push           = accept && (do_write || in_data.opcode == OP_CLEAR);
  assign job_data.is_clear  = (in_data.opcode == OP_CLEAR);
  assign job_data.addr      = row_base + {3'b000, wr_col};
  assign job_data.char_code = in_data.char_code;

endmodule

`default_nettype wire

FILE: hw/rtl/cdcf_job_fifo.sv
// short job queue between front and back end
`default_nettype none

module cdcf_job_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cdcf_pkg::job_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output cdcf_pkg::job_t      head
);
  import cdcf_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cdcf_back.sv
// back end: serializes frame jobs into link bytes through an output register
`default_nettype none

module cdcf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  input  wire cdcf_pkg::job_t job_head,
  output logic                job_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output cdcf_pkg::out_item_t out_data
);
  import cdcf_pkg::*;

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic       load;
  logic       last;
  logic [7:0] byte_sel;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign load      = !out_valid_r || out_pop;

  // byte for the current step of the frame
  always_comb begin
    byte_sel = START_CMD;
    if (job_head.is_clear) begin
      unique case (step_r)
        3'd0:    byte_sel = START_CMD;
        3'd1:    byte_sel = {4'h0, CLEAR_CMD[3:0]};
        default: byte_sel = {4'h0, CLEAR_CMD[7:4]};
      endcase
    end else begin
      unique case (step_r)
        3'd0:    byte_sel = START_CMD;
        3'd1:    byte_sel = {4'h0, job_head.addr[3:0]};
        3'd2:    byte_sel = {4'h0, job_head.addr[7:4]};
        3'd3:    byte_sel = START_DATA;
        3'd4:    byte_sel = {4'h0, job_head.char_code[3:0]};
        default: byte_sel = {4'h0, job_head.char_code[7:4]};
      endcase
    end
  end

  assign last = job_head.is_clear ? (step_r == STEP_CLEAR_LAST) :
                                    (step_r == STEP_WRITE_LAST);

  // output register load and step sequencing
  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    job_pop       = 1'b0;
    if (load) begin
      out_valid_nxt = job_valid;
      if (job_valid) begin
        out_nxt.link_byte = byte_sel;
        out_nxt.is_last   = last;
        step_nxt          = last ? 3'd0 : step_r + 3'd1;
        job_pop           = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/char_display_cursor_framer_top.sv
// Character display cursor framer: turns write, set-cursor and clear requests
// into link bytes for a serially attached character display. Requests enter a
// front end that tracks the cursor and queues frame jobs (up to four) for a
// back end that sends one link byte per cycle through an output register while
// the receiver keeps popping. A write request makes six bytes, a clear three; a
// set-cursor request or an out-of-range positioned write makes no bytes.
// Sustained write throughput is set by the one-byte-per-cycle serializer.
// Configuration registers take a write in any cycle; change them only while the
// block is idle.
`default_nettype none

module char_display_cursor_framer_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire cdcf_pkg::in_item_t               in_data,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output cdcf_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cdcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cdcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cdcf_pkg::*;

  logic job_push, job_full, job_pop, job_valid;
  job_t job_in, job_head;

  // request intake and cursor
  cdcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_full  (job_full),
    .job_push  (job_push),
    .job_data  (job_in)
  );

  // job queue
  cdcf_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .valid     (job_valid),
    .head      (job_head)
  );

  // byte serializer
  cdcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: dv/cdcf_checker.sv
// link byte checker for the character display cursor framer
`timescale 1ns / 100ps

module cdcf_checker
  import cdcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  in_item_t              in_data,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    bytes_pending
);

  // link bytes still owed by the block, oldest first
  out_item_t            link_queue[$];
  logic [LINES_W-1:0]   lines_reg;
  logic [COLUMNS_W-1:0] columns_reg;
  logic [COL_W-1:0]     cursor_col;
  logic [ROW_W-1:0]     cursor_row;
  int                   mismatches;

  initial begin
    fail_count    = 0;
    bytes_pending = 0;
    mismatches    = 0;
  end

  // bounds clamp oversized settings to the display limits
  function automatic int usable_columns();
    return (int'(columns_reg) > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_reg);
  endfunction

  function automatic int usable_rows();
    return (int'(lines_reg) > MAX_ROWS) ? MAX_ROWS : int'(lines_reg);
  endfunction

  function automatic void queue_link(input logic [7:0] lb, input logic last);
    out_item_t item;
    item.link_byte = lb;
    item.is_last   = last;
    link_queue.push_back(item);
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
  endfunction

  // six-byte write frame at the cursor, then advance and wrap the cursor
  function automatic void frame_write(input logic [7:0] ch);
    logic [7:0] base;
    logic [7:0] addr;
    int         next_col;
    int         next_row;
    case (cursor_row)
      2'd0: base = ROW_BASE_0;
      2'd1: base = (lines_reg == 3'd2) ? ROW_BASE_2 : ROW_BASE_1;
      2'd2: base = ROW_BASE_2;
      default: base = ROW_BASE_3;
    endcase
    addr = base + 8'(cursor_col);
    queue_link(START_CMD, 1'b0);
    queue_link({4'h0, addr[3:0]}, 1'b0);
    queue_link({4'h0, addr[7:4]}, 1'b0);
    queue_link(START_DATA, 1'b0);
    queue_link({4'h0, ch[3:0]}, 1'b0);
    queue_link({4'h0, ch[7:4]}, 1'b1);
    next_col = int'(cursor_col) + 1;
    next_row = int'(cursor_row);
    if (next_col >= usable_columns() || next_col > 31) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= usable_rows()) next_row = 0;
    cursor_col = COL_W'(next_col);
    cursor_row = ROW_W'(next_row);
  endfunction

  // expected link bytes and cursor update for one accepted request
  function automatic void predict_request(input in_item_t req);
    bit on_screen;
    on_screen = (int'(req.target_col) < usable_columns()) &&
                (int'(req.target_row) < usable_rows());
    case (req.opcode)
      OP_WRITE_AT: begin
        if (on_screen) begin
          cursor_col = req.target_col[COL_W-1:0];
          cursor_row = req.target_row[ROW_W-1:0];
          frame_write(req.char_code);
        end
      end
      OP_WRITE_CUR: begin
        frame_write(req.char_code);
      end
      OP_SET_CUR: begin
        if (on_screen) begin
          cursor_col = req.target_col[COL_W-1:0];
          cursor_row = req.target_row[ROW_W-1:0];
        end else begin
          cursor_col = '0;
          cursor_row = '0;
        end
      end
      OP_CLEAR: begin
        queue_link(START_CMD, 1'b0);
        queue_link({4'h0, CLEAR_CMD[3:0]}, 1'b0);
        queue_link({4'h0, CLEAR_CMD[7:4]}, 1'b1);
        cursor_col = '0;
        cursor_row = '0;
      end
    endcase
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      link_queue.delete();
      lines_reg   = LINE_COUNT_RST;
      columns_reg = COLUMN_COUNT_RST;
      cursor_col  = '0;
      cursor_row  = '0;
    end else begin
      // compare a popped byte with the oldest expectation
      if (out_pop && !out_empty) begin
        if (link_queue.size() == 0) begin
          flag_error($sformatf("link byte %02h (last %0b) with no request outstanding",
                               out_data.link_byte, out_data.is_last));
        end else begin
          want = link_queue.pop_front();
          if (out_data.link_byte !== want.link_byte)
            flag_error($sformatf("link_byte expected %02h, got %02h",
                                 want.link_byte, out_data.link_byte));
          if (out_data.is_last !== want.is_last)
            flag_error($sformatf("is_last expected %0b, got %0b (byte %02h)",
                                 want.is_last, out_data.is_last, want.link_byte));
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINE_COUNT:   lines_reg   = cfg_data[LINES_W-1:0];
          CFG_COLUMN_COUNT: columns_reg = cfg_data[COLUMNS_W-1:0];
          default: ;
        endcase
      end
      // accepted request
      if (in_push && !in_full) predict_request(in_data);
    end
    fail_count    <= mismatches;
    bytes_pending <= link_queue.size();
  end

endmodule

FILE: dv/tb_char_display_cursor_framer_top.sv
// testbench top for the character display cursor framer: stimulus and verdict
`timescale 1ns / 100ps

module tb_char_display_cursor_framer_top;
  import cdcf_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  in_item_t              in_data;
  logic                  out_empty;
  logic                  out_pop;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    bytes_pending;

  // idling enable, receiver hold-off trigger, current geometry
  bit gaps_on;
  bit rx_hold_go;
  int stim_lines;
  int stim_cols;

  // geometry settings, one per random phase
  int phase_lines [9] = '{2, 4, 7, 0, 3, 1, 4, 2, 1};
  int phase_cols  [9] = '{16, 32, 63, 0, 5, 32, 1, 20, 1};

  char_display_cursor_framer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cdcf_checker link_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data       (in_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic [1:0] op, input logic [7:0] col,
                              input logic [7:0] row, input logic [7:0] ch);
    in_item_t req;
    req.opcode     = op;
    req.target_col = col;
    req.target_row = row;
    req.char_code  = ch;
    while (gaps_on && $urandom_range(99) < 38) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_full);
  endtask

  // random request, mostly on screen so that writes get through
  task automatic send_random();
    int         pick;
    int         col_lim;
    int         row_lim;
    logic [1:0] op;
    logic [7:0] col;
    logic [7:0] row;
    col_lim = (stim_cols > MAX_COLUMNS) ? MAX_COLUMNS : stim_cols;
    row_lim = (stim_lines > MAX_ROWS) ? MAX_ROWS : stim_lines;
    pick = $urandom_range(99);
    if (pick < 35) op = OP_WRITE_AT;
    else if (pick < 65) op = OP_WRITE_CUR;
    else if (pick < 80) op = OP_SET_CUR;
    else op = OP_CLEAR;
    col = ($urandom_range(3) != 0 && col_lim > 0) ? 8'($urandom_range(col_lim - 1))
                                                   : 8'($urandom_range(255));
    row = ($urandom_range(3) != 0 && row_lim > 0) ? 8'($urandom_range(row_lim - 1))
                                                   : 8'($urandom_range(255));
    send_request(op, col, row, 8'($urandom_range(255)));
  endtask

  // stop offering and wait until every expected byte has come out
  task automatic wait_drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no lowering
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input int lines, input int cols);
    cfg_write(CFG_LINE_COUNT, CFG_DATA_W'(lines));
    cfg_write(CFG_COLUMN_COUNT, CFG_DATA_W'(cols));
    cfg_valid <= 1'b0;
    stim_lines = lines;
    stim_cols  = cols;
  endtask

  // receiver: random pops, plus one long hold-off on request
  initial begin
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_go) begin
        rx_hold_go = 1'b0;
        out_pop <= 1'b0;
        for (int n = 0; n < 200; n++) @(posedge clk);
      end else begin
        out_pop <= !(gaps_on && $urandom_range(99) < 38);
        @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_n      <= 1'b0;
    in_push    <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_LINE_COUNT;
    cfg_data   <= '0;
    gaps_on    = 1'b1;
    rx_hold_go = 1'b0;
    stim_lines = LINE_COUNT_RST;
    stim_cols  = COLUMN_COUNT_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset geometry of four rows by twenty columns
    send_request(OP_CLEAR,     8'hFF, 8'hFF, 8'hFF);
    send_request(OP_WRITE_AT,  8'h00, 8'h00, 8'h00);
    send_request(OP_WRITE_AT,  8'd19, 8'd3,  8'hFF);
    send_request(OP_WRITE_CUR, 8'hFF, 8'hFF, 8'hA5);
    send_request(OP_WRITE_AT,  8'd20, 8'd0,  8'h11);
    send_request(OP_WRITE_AT,  8'd0,  8'd4,  8'h22);
    send_request(OP_WRITE_AT,  8'hFF, 8'hFF, 8'h33);
    send_request(OP_SET_CUR,   8'd19, 8'd0,  8'h00);
    send_request(OP_WRITE_CUR, 8'h00, 8'h00, 8'h5A);
    send_request(OP_WRITE_CUR, 8'h00, 8'h00, 8'hC3);
    send_request(OP_SET_CUR,   8'hFF, 8'hFF, 8'hFF);
    send_request(OP_WRITE_CUR, 8'h00, 8'h00, 8'h3C);
    send_request(OP_SET_CUR,   8'd7,  8'd2,  8'h00);
    send_request(OP_WRITE_CUR, 8'h00, 8'h00, 8'h96);
    // park the cursor where the next geometry no longer reaches
    send_request(OP_SET_CUR,   8'd19, 8'd3,  8'h00);

    for (int p = 0; p < 9; p++) begin
      wait_drain();
      set_config(phase_lines[p], phase_cols[p]);
      if (p == 0) begin
        // cursor outside the shrunken display, then the two-line row base
        send_request(OP_WRITE_CUR, 8'h00, 8'h00, 8'h81);
        send_request(OP_WRITE_AT,  8'd5,  8'd1,  8'h44);
        gaps_on = 1'b0;
      end
      if (p == 1) begin
        // last cell of a full-size display, then wrap to home
        send_request(OP_WRITE_AT,  8'd31, 8'd3,  8'hFF);
        send_request(OP_WRITE_CUR, 8'h00, 8'h00, 8'h00);
        rx_hold_go = 1'b1;
      end
      for (int i = 0; i < 34; i++) send_random();
      gaps_on = 1'b1;
    end

    wait_drain();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
